// ----- rtl/tlv_record_parser_top_defines.svh -----
// ============================================================================
// TLV record parser assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef TLV_RECORD_PARSER_TOP_DEFINES_SVH
`define TLV_RECORD_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLV_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tlv_rp_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// TLV record parser package
// Item types shared by the parser modules, plus the parse phase codes and word sizes used by the parser core.
// ============================================================================
package tlv_rp_pkg;

    localparam int unsigned HEADER_BYTES = 5;
    localparam int unsigned WORD16_BYTES = 2;
    localparam int unsigned WORD32_BYTES = 4;
    localparam int unsigned WORD64_BYTES = 8;

    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_LEN0  = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LEN2  = 3'd3,
        PH_LEN3  = 3'd4,
        PH_VALUE = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  record_tag;
        logic [31:0] record_length;
        logic        has_byte;
        logic [7:0]  value_byte;
        logic [31:0] byte_offset;
        logic        record_done;
        logic [15:0] word16;
        logic [31:0] word32;
        logic [63:0] word64;
        logic        truncated;
    } t_out_item;

endpackage

// ----- rtl/tlv_rp_parser.sv -----
`timescale 1ns / 1ps
// ============================================================================
// TLV record parser core
// Holds the record state and forms at most one result for each byte.
// ============================================================================
module tlv_rp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  tlv_rp_pkg::t_in_item i_item,
    output logic                 o_res_valid,
    output tlv_rp_pkg::t_out_item o_res
);
    import tlv_rp_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_tag,    n_tag;
    logic [31:0] r_length, n_length;
    logic [31:0] r_count,  n_count;
    logic [63:0] r_head,   n_head;

    logic [7:0]  b;
    logic        last;
    logic        hdr_byte;
    logic        zero_len;
    logic        done;
    logic [31:0] count_inc;

    assign b    = i_item.data_byte;
    assign last = i_item.buffer_end;
    assign count_inc = r_count + 32'd1;

    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_length = r_length;
        n_count  = r_count;
        n_head   = r_head;
        hdr_byte = 1'b0;
        zero_len = 1'b0;
        done     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_valid) begin
            case (r_phase)
                PH_LEN0: begin
                    n_length[7:0] = b;
                    n_phase  = PH_LEN1;
                    hdr_byte = 1'b1;
                end
                PH_LEN1: begin
                    n_length[15:8] = b;
                    n_phase  = PH_LEN2;
                    hdr_byte = 1'b1;
                end
                PH_LEN2: begin
                    n_length[23:16] = b;
                    n_phase  = PH_LEN3;
                    hdr_byte = 1'b1;
                end
                PH_LEN3: begin
                    n_length[31:24] = b;
                    if (n_length == 32'd0) begin
                        zero_len = 1'b1;
                        n_phase  = PH_TAG;
                    end else begin
                        n_phase  = PH_VALUE;
                        hdr_byte = 1'b1;
                    end
                end
                PH_VALUE: begin
                    if (r_count[31:3] == 29'd0) begin
                        n_head[{r_count[2:0], 3'b000} +: 8] = b;
                    end
                    n_count = count_inc;
                    done    = (count_inc == r_length);
                    if (done) begin
                        n_phase = PH_TAG;
                    end
                end
                default: begin
                    // Tag byte; the unused phase codes land here as well.
                    n_tag    = b;
                    n_length = '0;
                    n_count  = '0;
                    n_head   = '0;
                    n_phase  = PH_LEN0;
                    hdr_byte = 1'b1;
                end
            endcase

            o_res.record_tag = n_tag;
            if (zero_len) begin
                o_res_valid       = 1'b1;
                o_res.record_done = 1'b1;
            end else if (r_phase == PH_VALUE) begin
                o_res_valid         = 1'b1;
                o_res.record_length = r_length;
                o_res.has_byte      = 1'b1;
                o_res.value_byte    = b;
                o_res.byte_offset   = r_count;
                o_res.record_done   = done;
                o_res.truncated     = !done && last;
                if (done && r_length >= WORD16_BYTES) begin
                    o_res.word16 = n_head[15:0];
                end
                if (done && r_length >= WORD32_BYTES) begin
                    o_res.word32 = n_head[31:0];
                end
                if (done && r_length >= WORD64_BYTES) begin
                    o_res.word64 = n_head;
                end
            end else if (hdr_byte && last) begin
                o_res_valid     = 1'b1;
                o_res.truncated = 1'b1;
            end

            if (last) begin
                n_phase = PH_TAG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TAG;
            r_tag    <= '0;
            r_length <= '0;
            r_count  <= '0;
            r_head   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_tag    <= n_tag;
            r_length <= n_length;
            r_count  <= n_count;
            r_head   <= n_head;
        end
    end

endmodule

// ----- rtl/tlv_rp_out_buf.sv -----
`timescale 1ns / 1ps
// ============================================================================
// TLV record parser output buffer
// Result register with a skid stage so input and output stall independently.
// ============================================================================
module tlv_rp_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tlv_rp_pkg::t_out_item i_item,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_stall,
    output tlv_rp_pkg::t_out_item o_item
);
    import tlv_rp_pkg::*;

    logic      r_main_valid, r_skid_valid;
    t_out_item r_main, r_skid;
    logic      pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_item;
            end else begin
                r_skid <= i_item;
            end
        end
    end

endmodule

// ----- rtl/tlv_record_parser_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// TLV record parser
// Streaming parser for one-byte-tag, four-byte-length value records.
// ============================================================================
// The block takes a buffer one byte per item, with buffer_end set on the last
// byte, and splits it into records of a tag byte, a four-byte little-endian
// length and that many value bytes. Each value byte leaves as one result item
// with its tag, declared length and offset; the last byte of a record also
// sets record_done and carries the first 2, 4 and 8 value bytes as
// little-endian words, each zero when the record is shorter than the word. A
// zero-length record yields a single done item on its last length byte. When
// the buffer ends inside a header or a value the block emits an item with
// truncated set, which the consumer should treat as a discarded record, and
// parsing restarts with a tag byte at the next buffer. Header bytes other than
// that case produce no result. One item is accepted every clock cycle while
// o_in_stall is low: the record state is registered and the result lands in
// an output register. A two-deep output buffer (result register plus skid
// stage) lets the input keep flowing while one result waits; o_in_stall rises
// only when both stages are full.
// ============================================================================
module tlv_record_parser_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input byte channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tlv_rp_pkg::t_in_item  i_in_item,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tlv_rp_pkg::t_out_item o_out_item
);
    import tlv_rp_pkg::*;

`include "tlv_record_parser_top_defines.svh"

    logic      in_accept;
    logic      res_valid;
    t_out_item res;

    // The stall is taken straight from the skid flag, so it never depends
    // combinationally on the downstream stall.
    assign in_accept = i_in_valid && !o_in_stall;

    tlv_rp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_accept),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tlv_rp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_item  (res),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    // A filled skid stage always sits behind a filled result register.
    `TLV_ASSERT_IMPLY(a_skid_behind_main, o_in_stall, o_out_valid, "skid full, main empty")

    // A full buffer drains its skid stage as soon as the consumer takes an item.
    `TLV_ASSERT_NEXT(a_skid_drains, o_in_stall && !i_out_stall, !o_in_stall, "skid not drained")

    // A record is either complete or cut short, never both.
    `TLV_ASSERT_IMPLY(a_done_not_trunc, o_out_valid, !(o_out_item.record_done && o_out_item.truncated), "done and truncated")

    // Items without a value byte carry no byte and no offset.
    `TLV_ASSERT_IMPLY(a_no_byte_zero, o_out_valid && !o_out_item.has_byte, o_out_item.value_byte == 8'd0 && o_out_item.byte_offset == 32'd0, "stray value byte")

endmodule
